// File: rtl/sum8_packet_frame_checker_unit_assert.svh
// assertion macros for the frame checker
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef SUM8_PACKET_FRAME_CHECKER_UNIT_ASSERT_SVH
`define SUM8_PACKET_FRAME_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication
`define SFC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sfc assertion failed");

// next-cycle implication
`define SFC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sfc assertion failed");

`endif

// File: rtl/sfc_pkg.sv
// shared types and constants of the sum8 frame checker
// no dependencies
package sfc_pkg;

  localparam int unsigned CountWidth = 17;
  localparam int unsigned LenWidth   = 16;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_SHORT = 3'd1,
    ST_LEN   = 3'd2,
    ST_TYPE  = 3'd3,
    ST_SUM   = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0] echo_byte;
    logic       is_payload;
    logic       frame_done;
    status_e    status;
  } result_t;

endpackage

// File: rtl/sfc_track.sv
// frame state tracking and status decision for one byte beat
// depends on sfc_pkg and sum8_packet_frame_checker_unit_assert.svh
`include "sum8_packet_frame_checker_unit_assert.svh"

module sfc_track (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  input  logic [7:0]            expected_type_i,
  output sfc_pkg::result_t      result_o
);

  logic [sfc_pkg::CountWidth-1:0] count_q, count_d;
  logic [7:0]                     type_q, type_d;
  logic [sfc_pkg::LenWidth-1:0]   len_q, len_d;
  logic [7:0]                     sum_q, sum_d;
  logic [sfc_pkg::CountWidth-1:0] pos_off;
  logic                           pos_ge3;
  logic                           in_payload;
  sfc_pkg::status_e               status;

  assign pos_ge3 = count_q >= sfc_pkg::CountWidth'(3);
  assign pos_off = count_q - sfc_pkg::CountWidth'(3);
  assign in_payload = pos_ge3 && (pos_off < {1'b0, len_q}) && !last_byte_i;

  always_comb begin
    status = sfc_pkg::ST_OK;
    if (last_byte_i) begin
      priority if (count_q < sfc_pkg::CountWidth'(2)) begin
        status = sfc_pkg::ST_SHORT;
      end else if (!pos_ge3 || ({1'b0, len_q} != pos_off)) begin
        status = sfc_pkg::ST_LEN;
      end else if (type_q != expected_type_i) begin
        status = sfc_pkg::ST_TYPE;
      end else if (sum_q != data_byte_i) begin
        status = sfc_pkg::ST_SUM;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    type_d  = type_q;
    len_d   = len_q;
    sum_d   = sum_q;
    if (last_byte_i) begin
      count_d = '0;
      type_d  = '0;
      len_d   = '0;
      sum_d   = '0;
    end else begin
      if (count_q == sfc_pkg::CountWidth'(0)) begin
        type_d = data_byte_i;
      end
      if (count_q == sfc_pkg::CountWidth'(1)) begin
        len_d[7:0] = data_byte_i;
      end
      if (count_q == sfc_pkg::CountWidth'(2)) begin
        len_d[15:8] = data_byte_i;
      end
      sum_d = sum_q + data_byte_i;
      if (count_q != '1) begin
        count_d = count_q + sfc_pkg::CountWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      type_q  <= '0;
      len_q   <= '0;
      sum_q   <= '0;
    end else if (adv_i) begin
      count_q <= count_d;
      type_q  <= type_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
    end
  end

  assign result_o.echo_byte  = data_byte_i;
  assign result_o.is_payload = in_payload;
  assign result_o.frame_done = last_byte_i;
  assign result_o.status     = status;

  `SFC_ASSERT_NOW(a_status_only_on_last, !last_byte_i, status == sfc_pkg::ST_OK)
  `SFC_ASSERT_NEXT(a_clear_after_last, adv_i && last_byte_i, count_q == '0 && sum_q == '0)
  `SFC_ASSERT_NOW(a_payload_after_header, in_payload, pos_ge3 && !last_byte_i)

endmodule

// File: rtl/sum8_packet_frame_checker_unit.sv
// top level of the sum8 frame checker: input beat register, result register, config
// depends on sfc_pkg, sfc_track and sum8_packet_frame_checker_unit_assert.svh
//
// usage
//   in channel: one received byte per beat (data_byte_i, last_byte_i marks the checksum)
//   out channel: one result beat per input beat, in order: the byte echoed, a payload
//     flag, frame_done on the last byte and its status (0 ok, 1 too short, 2 length
//     mismatch, 3 type mismatch, 4 checksum bad), status is 0 when frame_done is 0
//   cfg channel: writes expected_type; cfg_ready_o is always high, write only when idle
//   order: a byte waits in the input register, its result in the result register
//   throughput: one byte per cycle while out_ready_i is high; the frame counter,
//     running sum and header fields update in the same cycle as a byte moves from the
//     input register to the result register
//   stall: while out_ready_i is low the result holds; one more byte can wait in the
//     input register, then in_ready_o drops until the result is taken
//   reset: clears both valid flags, the frame state and expected_type to zero
`include "sum8_packet_frame_checker_unit_assert.svh"

module sum8_packet_frame_checker_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] echo_byte_o,
  output logic       is_payload_o,
  output logic       frame_done_o,
  output logic [2:0] status_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  logic             s1_valid_q;
  logic [7:0]       s1_byte_q;
  logic             s1_last_q;
  logic             s1_adv;
  logic             out_free;
  logic [7:0]       exp_type_q;
  logic             res_valid_q;
  sfc_pkg::result_t res_q;
  sfc_pkg::result_t res_d;

  assign out_free   = !res_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_type_q <= '0;
    end else if (cfg_valid_i) begin
      exp_type_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  sfc_track u_track (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (s1_adv),
    .data_byte_i     (s1_byte_q),
    .last_byte_i     (s1_last_q),
    .expected_type_i (exp_type_q),
    .result_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_free) begin
      res_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = res_valid_q;
  assign echo_byte_o  = res_q.echo_byte;
  assign is_payload_o = res_q.is_payload;
  assign frame_done_o = res_q.frame_done;
  assign status_o     = res_q.status;

  `SFC_ASSERT_NEXT(a_s1_holds_on_stall, s1_valid_q && !out_free, s1_valid_q && $stable(s1_byte_q))
  `SFC_ASSERT_NEXT(a_adv_fills_result, s1_adv, res_valid_q)

endmodule

// File: sim/tb_sum8_packet_frame_checker_unit.sv
// self-checking testbench of sum8_packet_frame_checker_unit: random and directed frames
// go through a queue-fed driver, results are checked beat by beat against a predictor
// depends on sfc_pkg and the rtl of sum8_packet_frame_checker_unit
`timescale 1ns / 1ps

module tb_sum8_packet_frame_checker_unit;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainCycles = 8;
  localparam logic [sfc_pkg::CountWidth-1:0] CountMax = '1;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] echo_byte_o;
  logic       is_payload_o;
  logic       frame_done_o;
  logic [2:0] status_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i = 8'h00;

  byte_beat_t       pending_beats[$];
  sfc_pkg::result_t expected_results[$];

  // predictor state
  logic [sfc_pkg::CountWidth-1:0] frame_pos_q = '0;
  logic [7:0]                     frame_type_q = 8'h00;
  logic [sfc_pkg::LenWidth-1:0]   frame_len_q = '0;
  logic [7:0]                     frame_sum_q = 8'h00;
  logic [7:0]                     accept_type_q = 8'h00;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned beats_pushed = 0;
  bit          in_fire = 1'b0;

  sum8_packet_frame_checker_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .echo_byte_o (echo_byte_o),
    .is_payload_o(is_payload_o),
    .frame_done_o(frame_done_o),
    .status_o    (status_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic predict_frame_byte(input logic [7:0] b, input logic last);
    sfc_pkg::result_t r;
    int unsigned      pos;
    int unsigned      size;
    pos = frame_pos_q;
    if (pos == 0) begin
      frame_type_q = b;
    end else if (pos == 1) begin
      frame_len_q[7:0] = b;
    end else if (pos == 2) begin
      frame_len_q[15:8] = b;
    end
    r.echo_byte  = b;
    r.is_payload = (pos >= 3) && ((pos - 3) < frame_len_q) && !last;
    r.frame_done = last;
    r.status     = sfc_pkg::ST_OK;
    if (last) begin
      size = pos + 1;
      if (size < 3) begin
        r.status = sfc_pkg::ST_SHORT;
      end else if (size < 4 || frame_len_q != size - 4) begin
        r.status = sfc_pkg::ST_LEN;
      end else if (frame_type_q != accept_type_q) begin
        r.status = sfc_pkg::ST_TYPE;
      end else if (frame_sum_q != b) begin
        r.status = sfc_pkg::ST_SUM;
      end
      frame_pos_q  = '0;
      frame_type_q = 8'h00;
      frame_len_q  = '0;
      frame_sum_q  = 8'h00;
    end else begin
      frame_sum_q = frame_sum_q + b;
      if (frame_pos_q < CountMax) frame_pos_q = frame_pos_q + 1'b1;
    end
    expected_results.insert(expected_results.size(), r);
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk_i) begin
    logic       nv;
    byte_beat_t bt;
    if (rst_ni) begin
      nv = in_valid_i;
      if (in_fire) nv = 1'b0;
      in_fire = 1'b0;
      if (!nv && pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        bt = pending_beats.pop_front();
        data_byte_i <= bt.data;
        last_byte_i <= bt.last;
        nv = 1'b1;
      end
      in_valid_i  <= nv;
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: everything sampled on the rising edge
  always @(posedge clk_i) begin
    sfc_pkg::result_t exp_r;
    bit               moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && in_ready_o) begin
        predict_frame_byte(data_byte_i, last_byte_i);
        in_fire = 1'b1;
        moved = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) moved = 1'b1;
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected result beat: echo %h pay %b done %b status %0d",
                     echo_byte_o, is_payload_o, frame_done_o, status_o);
          end
        end else begin
          exp_r = expected_results.pop_front();
          if (echo_byte_o !== exp_r.echo_byte || is_payload_o !== exp_r.is_payload ||
              frame_done_o !== exp_r.frame_done || status_o !== exp_r.status) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("result mismatch: expected echo %h pay %b done %b status %0d, got %h %b %b %0d",
                       exp_r.echo_byte, exp_r.is_payload, exp_r.frame_done, exp_r.status,
                       echo_byte_o, is_payload_o, frame_done_o, status_o);
            end
          end
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  task automatic queue_beat(input logic [7:0] b, input logic last);
    byte_beat_t bt;
    bt.data = b;
    bt.last = last;
    pending_beats.insert(pending_beats.size(), bt);
    beats_pushed++;
  endtask

  task automatic push_frame(input logic [7:0] ftype, input logic [15:0] len_field,
                            input int n_payload, input logic [7:0] sum_err);
    logic [7:0] sum;
    logic [7:0] b;
    sum = ftype + len_field[7:0] + len_field[15:8];
    queue_beat(ftype, 1'b0);
    queue_beat(len_field[7:0], 1'b0);
    queue_beat(len_field[15:8], 1'b0);
    for (int i = 0; i < n_payload; i++) begin
      b = 8'($urandom);
      sum = sum + b;
      queue_beat(b, 1'b0);
    end
    queue_beat(sum + sum_err, 1'b1);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_beats.size() != 0 || in_valid_i || expected_results.size() != 0);
  endtask

  task automatic write_accept_type(input logic [7:0] value);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    accept_type_q = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_random_frames(input int unsigned n_beats);
    int unsigned start;
    int unsigned kind;
    int unsigned plen;
    int unsigned n;
    logic        last;
    start = beats_pushed;
    while (beats_pushed - start < n_beats) begin
      kind = $urandom_range(0, 19);
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
      case (kind)
        12: push_frame(accept_type_q, 16'(plen), int'(plen), 8'($urandom_range(1, 255)));
        13: push_frame(accept_type_q ^ 8'($urandom_range(1, 255)), 16'(plen), int'(plen),
                       8'h00);
        14: begin
          if (plen > 0 && $urandom_range(1) == 1) n = $urandom_range(0, plen - 1);
          else n = plen + $urandom_range(1, 3);
          push_frame(accept_type_q, 16'(plen), int'(n), 8'h00);
        end
        15: begin
          n = $urandom_range(1, 3);
          for (int i = 1; i < n; i++) queue_beat(8'($urandom), 1'b0);
          queue_beat(8'($urandom), 1'b1);
        end
        16: begin
          do begin
            last = ($urandom_range(0, 3) == 0);
            queue_beat(8'($urandom), last);
          end while (!last);
        end
        17: push_frame(8'($urandom), 16'($urandom), int'(plen), 8'($urandom));
        default: push_frame(accept_type_q, 16'(plen), int'(plen), 8'h00);
      endcase
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 14;
    recv_idle_pct = 81;
    write_accept_type(8'h00);
    // header byte marked last: 1-2 byte frames too short, a 3-byte frame a length mismatch
    queue_beat(8'hFF, 1'b1);
    queue_beat(8'h00, 1'b0);
    queue_beat(8'hFF, 1'b1);
    queue_beat(8'h00, 1'b0);
    queue_beat(8'h00, 1'b0);
    queue_beat(8'h00, 1'b1);
    push_frame(8'h00, 16'd0, 0, 8'h00);
    push_frame(8'h00, 16'd0, 0, 8'h01);
    push_frame(8'hFF, 16'd0, 0, 8'h00);
    push_frame(8'h00, 16'd1, 1, 8'h00);
    push_frame(8'h00, 16'd1, 0, 8'h00);

    write_accept_type(8'hFF);
    push_random_frames(300);
    // sender holds off until all results are back
    wait_drained();
    push_random_frames(300);

    send_idle_pct = 81;
    recv_idle_pct = 14;
    write_accept_type(8'($urandom));
    push_random_frames(500);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_accept_type(8'hA5);
    push_random_frames(500);
    push_frame(8'hA5, 16'd3, 3, 8'h00);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
